/* rtl/mete_pkg.sv */
// shared types and constants for the escape-time pixel evaluator
package mete_pkg;

   // configuration register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_RE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_IM  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HALF_WIDTH = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HALF_HGT   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS       = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS       = 3'd5;

   // grid limits the active dimensions saturate to
   localparam int GRID_COLS = 512;
   localparam int GRID_ROWS = 128;

   // color bands
   localparam logic [2:0] BAND_BLANK  = 3'd0;
   localparam logic [2:0] BAND_INSIDE = 3'd1;
   localparam logic [2:0] BAND_FAST   = 3'd2;
   localparam logic [2:0] BAND_MID    = 3'd3;
   localparam logic [2:0] BAND_SLOW   = 3'd4;
   localparam logic [2:0] BAND_BODY   = 3'd5;

   // datapath widths
   localparam int HALF_W = 31;
   localparam int DVS_W  = 10;             // divisor, dimension minus one
   localparam int MAG_W  = 10;             // numerator magnitude
   localparam int DVD_W  = MAG_W + HALF_W; // dividend, one divider cell per bit
   localparam int Z_W    = 32;
   localparam int PROD_W = 64;
   localparam int NEXT_W = 34;

   // one slot of the divider chain
   typedef struct packed {
      logic             vld;
      logic             tag;   // 0 real axis, 1 imaginary axis
      logic             neg;
      logic [DVS_W-1:0] dvs;
      logic [DVS_W-1:0] rem;
      logic [DVD_W-1:0] dq;    // dividend bits out at the top, quotient bits in at the bottom
   } div_slot_type;

endpackage

/* rtl/mete_div_cell.sv */
// one restoring division step, registered
module mete_div_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  mete_pkg::div_slot_type slot_in,
   output mete_pkg::div_slot_type slot_out
);
   import mete_pkg::*;

   div_slot_type   slot_ff;
   div_slot_type   slot_in_step;
   logic [DVS_W:0] trial;
   logic           ge;

   always_comb begin
      trial = {slot_in.rem, slot_in.dq[DVD_W-1]};
      ge    = trial >= {1'b0, slot_in.dvs};
      slot_in_step     = slot_in;
      slot_in_step.rem = ge ? DVS_W'(trial - {1'b0, slot_in.dvs}) : trial[DVS_W-1:0];
      slot_in_step.dq  = {slot_in.dq[DVD_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff.vld <= 1'b0;
      end else begin
         slot_ff.vld <= slot_in_step.vld;
      end
      slot_ff.tag <= slot_in_step.tag;
      slot_ff.neg <= slot_in_step.neg;
      slot_ff.dvs <= slot_in_step.dvs;
      slot_ff.rem <= slot_in_step.rem;
      slot_ff.dq  <= slot_in_step.dq;
   end

   assign slot_out = slot_ff;

endmodule

/* rtl/mete_div_chain.sv */
// row of division cells, one quotient bit per cell
module mete_div_chain (
   input  logic                  clock,
   input  logic                  reset,
   input  mete_pkg::div_slot_type slot_in,
   output mete_pkg::div_slot_type slot_out
);
   import mete_pkg::*;

   div_slot_type taps [DVD_W+1];

   assign taps[0] = slot_in;

   for (genvar g = 0; g < DVD_W; g++) begin : g_cell
      mete_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .slot_in  (taps[g]),
         .slot_out (taps[g+1])
      );
   end

   assign slot_out = taps[DVD_W];

endmodule

/* rtl/mete_orbit.sv */
// z = z*z + c iteration unit, one iteration per cycle
module mete_orbit #(
   parameter int MAX_ITERATIONS = 256
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [mete_pkg::Z_W-1:0]     cre,
   input  logic signed [mete_pkg::Z_W-1:0]     cim,
   output logic                                done,
   output logic [$clog2(MAX_ITERATIONS+1)-1:0] count
);
   import mete_pkg::*;

   localparam int IT_W = $clog2(MAX_ITERATIONS + 1);
   localparam logic signed [PROD_W-1:0] ESC_LIM  = 64'sd1 <<< 56;
   localparam logic signed [NEXT_W-1:0] COMP_LIM = 34'sd1 <<< 28;

   logic                     busy_ff, pend_ff, done_ff;
   logic [IT_W-1:0]          it_ff, count_ff, acc;
   logic signed [Z_W-1:0]    zr_ff, zi_ff;
   logic signed [PROD_W-1:0] prr, pii, pri, mag2, srr, sii, sri;
   logic signed [NEXT_W-1:0] nr, ni;
   logic                     sum_fail, bound_fail;

   always_comb begin
      prr  = PROD_W'(zr_ff) * PROD_W'(zr_ff);
      pii  = PROD_W'(zi_ff) * PROD_W'(zi_ff);
      pri  = PROD_W'(zr_ff) * PROD_W'(zi_ff);
      mag2 = prr + pii;
      srr  = prr >>> 27;
      sii  = pii >>> 27;
      sri  = pri >>> 26;
      nr   = srr[NEXT_W-1:0] - sii[NEXT_W-1:0] + NEXT_W'(cre);
      ni   = sri[NEXT_W-1:0] + NEXT_W'(cim);
      sum_fail   = pend_ff && (mag2 > ESC_LIM);
      bound_fail = (nr > COMP_LIM) || (nr < -COMP_LIM) || (ni > COMP_LIM) || (ni < -COMP_LIM);
      acc        = it_ff + IT_W'(pend_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         pend_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            pend_ff <= 1'b0;
            it_ff   <= '0;
            zr_ff   <= '0;
            zi_ff   <= '0;
         end else if (busy_ff) begin
            priority if (sum_fail) begin
               busy_ff  <= 1'b0;
               done_ff  <= 1'b1;
               count_ff <= it_ff;
            end else if (acc == IT_W'(MAX_ITERATIONS)) begin
               busy_ff  <= 1'b0;
               done_ff  <= 1'b1;
               count_ff <= acc;
            end else if (bound_fail) begin
               busy_ff  <= 1'b0;
               done_ff  <= 1'b1;
               count_ff <= acc;
            end else begin
               zr_ff   <= nr[Z_W-1:0];
               zi_ff   <= ni[Z_W-1:0];
               it_ff   <= acc;
               pend_ff <= 1'b1;
            end
         end
      end
   end

   assign done  = done_ff;
   assign count = count_ff;

endmodule

/* rtl/mandelbrot_escape_time_pixel_top.sv */
// top level of the escape-time pixel evaluator
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_ready  | req_col[8:0], req_row[6:0]
//  rsp     | out       | rsp_valid/rsp_ready  | rsp_band[2:0], rsp_iterations[8:0]
//  csr     | in        | csr_valid/csr_ready  | csr_index[2:0], csr_data[31:0]
//
// one pixel at a time: mapping (the real and imaginary multiplies, 41 divider
// cells, the add into the plane coordinates, the orbit start), then the orbit
// loop at one iteration per cycle, then the result hand-off; the orbit loop sets the pace
// reset is synchronous and loads the default view; the result sits in an output
// register, so a stalled rsp holds only the next pixel's finish, not its start
// csr is always ready and is meant to be written while the block is idle
module mandelbrot_escape_time_pixel_top #(
   parameter int MAX_ITERATIONS = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [8:0]  req_col,
   input  logic [6:0]  req_row,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_band,
   output logic [8:0]  rsp_iterations,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [mete_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0] csr_data
);
   import mete_pkg::*;

   localparam int IT_W = $clog2(MAX_ITERATIONS + 1);
   // band thresholds, exact integer form of the fractional banding
   localparam int TH_MID  = 13 * MAX_ITERATIONS;
   localparam int TH_SLOW = 22 * MAX_ITERATIONS;
   localparam int TH_BODY = 31 * MAX_ITERATIONS;
   localparam logic [12:0] GRID_COLS_V = 13'(GRID_COLS);
   localparam logic [12:0] GRID_ROWS_V = 13'(GRID_ROWS);

   typedef enum logic [2:0] {
      S_IDLE, S_MUL_RE, S_MUL_IM, S_DIV, S_COORD, S_ORBIT, S_HOLD
   } state_type;

   state_type state_ff;

   // view registers
   logic signed [Z_W-1:0] center_re_ff, center_im_ff;
   logic [HALF_W-1:0]     half_w_ff, half_h_ff;
   logic [9:0]            cols_ff;
   logic [7:0]            rows_ff;

   // pixel and results
   logic [8:0]            col_ff;
   logic [6:0]            row_ff;
   logic                  neg_re_ff, neg_im_ff;
   logic [DVD_W-1:0]      q_re_ff, q_im_ff;
   logic signed [Z_W-1:0] cre_ff, cim_ff;
   logic                  start_ff;
   logic [IT_W-1:0]       it_ff;
   logic                  rsp_valid_ff;
   logic [2:0]            band_ff;
   logic [8:0]            iters_ff;
   logic                  rsp_load;

   // mapping datapath
   logic [12:0]             cols_ext, rows_ext, cols_sat, rows_sat;
   logic [DVS_W-1:0]        n_col, n_row, dvs;
   logic                    flat_col, flat_row, flat, neg;
   logic signed [11:0]      num_re, num_im, num, num_abs;
   logic [MAG_W-1:0]        mag;
   logic [HALF_W-1:0]       half;
   logic [DVD_W-1:0]        prod;
   div_slot_type            div_in, div_out;
   logic signed [Z_W-1:0]   cre_in, cim_in;

   // orbit
   logic                    orbit_done;
   logic [IT_W-1:0]         orbit_count;
   logic [2:0]              band_in;

   // saturate a 43-bit sum to the Q5.27 range
   function automatic logic signed [Z_W-1:0] sat_q(input logic signed [42:0] v);
      logic signed [42:0] hi, lo;
      hi = 43'sh0_7FFF_FFFF;
      lo = -43'sh0_8000_0000;
      if (v > hi) begin
         sat_q = hi[Z_W-1:0];
      end else if (v < lo) begin
         sat_q = lo[Z_W-1:0];
      end else begin
         sat_q = v[Z_W-1:0];
      end
   endfunction

   // center plus signed quotient
   function automatic logic signed [Z_W-1:0] axis_c(input logic signed [Z_W-1:0] center,
                                                     input logic              ng,
                                                     input logic [DVD_W-1:0]  q);
      logic signed [42:0] off;
      off = ng ? -$signed({2'b00, q}) : $signed({2'b00, q});
      axis_c = sat_q(43'(center) + off);
   endfunction

   always_comb begin
      // active dimensions, clamped to the grid
      cols_ext = {3'b000, cols_ff};
      rows_ext = {5'b00000, rows_ff};
      cols_sat = (cols_ext > GRID_COLS_V) ? GRID_COLS_V : cols_ext;
      rows_sat = (rows_ext > GRID_ROWS_V) ? GRID_ROWS_V : rows_ext;
      flat_col = cols_sat <= 13'd1;
      flat_row = rows_sat <= 13'd1;
      n_col    = DVS_W'(cols_sat - 13'd1);
      n_row    = DVS_W'(rows_sat - 13'd1);

      // numerators: 2*col - n across, n - 2*row down (row zero at top)
      num_re = $signed({2'b00, col_ff, 1'b0}) - $signed({2'b00, n_col});
      num_im = $signed({2'b00, n_row}) - $signed({4'b0000, row_ff, 1'b0});

      // one axis per cycle into the divider chain
      if (state_ff == S_MUL_IM) begin
         num  = num_im;
         flat = flat_row;
         half = half_h_ff;
         dvs  = flat_row ? DVS_W'(1) : n_row;
      end else begin
         num  = num_re;
         flat = flat_col;
         half = half_w_ff;
         dvs  = flat_col ? DVS_W'(1) : n_col;
      end
      neg     = num[11] && !flat;
      num_abs = num[11] ? -num : num;
      mag     = flat ? '0 : num_abs[MAG_W-1:0];
      prod    = {{HALF_W{1'b0}}, mag} * {{MAG_W{1'b0}}, half};

      div_in.vld = (state_ff == S_MUL_RE) || (state_ff == S_MUL_IM);
      div_in.tag = state_ff == S_MUL_IM;
      div_in.neg = neg;
      div_in.dvs = dvs;
      div_in.rem = '0;
      div_in.dq  = prod;

      cre_in = axis_c(center_re_ff, neg_re_ff, q_re_ff);
      cim_in = axis_c(center_im_ff, neg_im_ff, q_im_ff);

      // band from the escape count
      priority if (32'(it_ff) >= MAX_ITERATIONS) begin
         band_in = BAND_INSIDE;
      end else if (32'(it_ff) * 10 < MAX_ITERATIONS) begin
         band_in = BAND_BLANK;
      end else if (32'(it_ff) * 40 >= TH_BODY) begin
         band_in = BAND_BODY;
      end else if (32'(it_ff) * 40 >= TH_SLOW) begin
         band_in = BAND_SLOW;
      end else if (32'(it_ff) * 40 >= TH_MID) begin
         band_in = BAND_MID;
      end else begin
         band_in = BAND_FAST;
      end
   end

   // result moves into the output register once it is free
   assign rsp_load = (state_ff == S_HOLD) && (!rsp_valid_ff || rsp_ready);

   mete_div_chain u_div (
      .clock    (clock),
      .reset    (reset),
      .slot_in  (div_in),
      .slot_out (div_out)
   );

   mete_orbit #(
      .MAX_ITERATIONS (MAX_ITERATIONS)
   ) u_orbit (
      .clock (clock),
      .reset (reset),
      .start (start_ff),
      .cre   (cre_ff),
      .cim   (cim_ff),
      .done  (orbit_done),
      .count (orbit_count)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         center_re_ff <= -32'sd67108864;
         center_im_ff <= '0;
         half_w_ff    <= 31'd335544320;
         half_h_ff    <= 31'd174483046;
         cols_ff      <= 10'd256;
         rows_ff      <= 8'd64;
      end else begin
         start_ff <= 1'b0;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         // register writes
         if (csr_valid) begin
            unique case (csr_index)
               CSR_CENTER_RE:  center_re_ff <= csr_data;
               CSR_CENTER_IM:  center_im_ff <= csr_data;
               CSR_HALF_WIDTH: half_w_ff    <= csr_data[HALF_W-1:0];
               CSR_HALF_HGT:   half_h_ff    <= csr_data[HALF_W-1:0];
               CSR_COLS:       cols_ff      <= csr_data[9:0];
               CSR_ROWS:       rows_ff      <= csr_data[7:0];
               default:        ;
            endcase
         end

         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  col_ff   <= req_col;
                  row_ff   <= req_row;
                  state_ff <= S_MUL_RE;
               end
            end
            S_MUL_RE: state_ff <= S_MUL_IM;
            S_MUL_IM: state_ff <= S_DIV;
            S_DIV: begin
               // real axis leaves the chain in the cycle before the imaginary axis
               if (div_out.vld) begin
                  if (div_out.tag) begin
                     q_im_ff   <= div_out.dq;
                     neg_im_ff <= div_out.neg;
                     state_ff  <= S_COORD;
                  end else begin
                     q_re_ff   <= div_out.dq;
                     neg_re_ff <= div_out.neg;
                  end
               end
            end
            S_COORD: begin
               cre_ff   <= cre_in;
               cim_ff   <= cim_in;
               start_ff <= 1'b1;
               state_ff <= S_ORBIT;
            end
            S_ORBIT: begin
               if (orbit_done) begin
                  it_ff    <= orbit_count;
                  state_ff <= S_HOLD;
               end
            end
            S_HOLD: begin
               // wait for the output register to free up
               if (rsp_load) begin
                  band_ff      <= band_in;
                  iters_ff     <= 9'(it_ff);
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready      = state_ff == S_IDLE;
   assign csr_ready      = 1'b1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_band       = band_ff;
   assign rsp_iterations = iters_ff;

endmodule

/* tb/mandelbrot_escape_time_pixel_top_test.sv */
// self-checking testbench for the escape-time pixel evaluator top level
module mandelbrot_escape_time_pixel_top_test;
   timeunit 1ns;
   timeprecision 1ps;
   import mete_pkg::*;

   localparam int ESCAPE_MAX   = 256;
   localparam int STALL_LIMIT  = 6000;   // cycles with no transaction on any channel
   localparam int DRAIN_CYCLES = 400;

   // view registers as the hardware sees them after the write masks
   typedef struct {
      logic signed [31:0] center_re;
      logic signed [31:0] center_im;
      logic [30:0]        half_width;
      logic [30:0]        half_height;
      logic [9:0]         cols;
      logic [7:0]         rows;
   } view_type;

   typedef struct {
      logic [2:0] band;
      logic [8:0] iterations;
   } pixel_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [8:0]  req_col = '0;
   logic [6:0]  req_row = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_band;
   logic [8:0]  rsp_iterations;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_CENTER_RE;
   logic [31:0] csr_data = '0;

   view_type  view;
   pixel_type expected_pixels[$];
   int        mismatches = 0;
   int        pixels_sent = 0;
   int        pixels_checked = 0;
   int        reg_writes = 0;
   int        burst_left = 0;
   int        quiet_cycles = 0;
   bit        rsp_stalls_on = 0;
   int        stall_left = 0;
   bit [5:0]  bands_seen = '0;

   mandelbrot_escape_time_pixel_top #(.MAX_ITERATIONS(ESCAPE_MAX)) DUT (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   // map one grid coordinate onto its axis of the complex plane
   function automatic logic signed [31:0] map_axis(logic signed [31:0] center,
         longint half, longint dim, longint pos, bit flip);
      longint n, num, sum;
      if (dim <= 1) return center;
      n = dim - 1;
      num = flip ? (n - 2 * pos) : (2 * pos - n);
      sum = longint'(center) + (num * half) / n;   // division truncates toward zero
      if (sum > 64'sd2147483647) return 32'sh7fffffff;
      if (sum < -64'sd2147483648) return 32'sh80000000;
      return sum[31:0];
   endfunction

   // iterate z = z*z + c until escape, products exact at 64 bits
   function automatic int orbit_length(logic signed [31:0] cre, logic signed [31:0] cim);
      longint zr, zi, nr, ni, lim;
      int     count;
      zr = 0;
      zi = 0;
      lim = 64'sd1 << 28;
      for (count = 0; count < ESCAPE_MAX; count++) begin
         nr = ((zr * zr) >>> 27) - ((zi * zi) >>> 27) + longint'(cre);
         ni = ((zr * zi) >>> 26) + longint'(cim);
         if (nr > lim || -nr > lim || ni > lim || -ni > lim) break;
         if (nr * nr + ni * ni > (64'sd4 << 54)) break;
         zr = nr;
         zi = ni;
      end
      return count;
   endfunction

   function automatic pixel_type pixel_escape(view_type v, logic [8:0] col, logic [6:0] row);
      pixel_type p;
      longint    cols, rows, b;
      int        it;
      cols = (v.cols > GRID_COLS) ? longint'(GRID_COLS) : longint'(v.cols);
      rows = (v.rows > GRID_ROWS) ? longint'(GRID_ROWS) : longint'(v.rows);
      it = orbit_length(map_axis(v.center_re, longint'(v.half_width), cols,
                                 longint'(col), 1'b0),
                        map_axis(v.center_im, longint'(v.half_height), rows,
                                 longint'(row), 1'b1));
      if (it >= ESCAPE_MAX) p.band = BAND_INSIDE;
      else if (10 * it < ESCAPE_MAX) p.band = BAND_BLANK;
      else begin
         b = 2 + (40 * it - 4 * ESCAPE_MAX) / (9 * ESCAPE_MAX);
         p.band = (b > 5) ? BAND_BODY : b[2:0];
      end
      p.iterations = it[8:0];
      return p;
   endfunction

   // ---------------------------------------------------------------- monitors

   task automatic report_mismatch(string what, int got, int want);
      $display("error at %0t: %s got %0d, expected %0d", $realtime, what, got, want);
      mismatches++;
   endtask

   // outputs are sampled at the falling edge, where every driver is settled;
   // a valid with ready there is the transaction taken at the next rising edge
   always @(negedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_pixels.size() == 0)
            report_mismatch("unexpected result, band", rsp_band, -1);
         else begin
            pixel_type want;
            want = expected_pixels.pop_front();
            if (rsp_band !== want.band) report_mismatch("band", rsp_band, want.band);
            if (rsp_iterations !== want.iterations)
               report_mismatch("iterations", rsp_iterations, want.iterations);
            if (rsp_band <= BAND_BODY) bands_seen[rsp_band] = 1'b1;
            pixels_checked++;
         end
      end
   end

   // watchdog: nothing moving on any channel for too long
   always @(negedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet_cycles = 0;
      else if (++quiet_cycles >= STALL_LIMIT) begin
         $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
         $display("mandelbrot_escape_time_pixel_top: mismatch");
         $finish;
      end
   end

   // receiver back-pressure: when enabled, runs of ready and stall of random length; else always ready
   always @(posedge clock) begin
      if (!rsp_stalls_on) rsp_ready <= 1'b1;
      else if (stall_left > 0) stall_left--;
      else begin
         rsp_ready <= ~rsp_ready;
         stall_left = $urandom_range(0, 20);
      end
   end

   // ---------------------------------------------------------------- drivers

   // one pixel transaction; sender sometimes idles between bursts of random length
   task automatic send_pixel(logic [8:0] col, logic [6:0] row);
      bit taken;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 8);
         if ($urandom_range(0, 2) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_col <= col;
      req_row <= row;
      do begin
         @(negedge clock);
         taken = req_ready;
         @(posedge clock);
      end while (!taken);
      expected_pixels.push_back(pixel_escape(view, col, row));
      pixels_sent++;
   endtask

   task automatic go_idle();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
   endtask

   // every transaction yields a result, so an empty queue plus margin means idle
   task automatic wait_drained();
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // leaves csr_valid high; the caller drops it after the last write
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [31:0] data);
      bit taken;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do begin
         @(negedge clock);
         taken = csr_ready;
         @(posedge clock);
      end while (!taken);
      case (idx)
         CSR_CENTER_RE:  view.center_re = data;
         CSR_CENTER_IM:  view.center_im = data;
         CSR_HALF_WIDTH: view.half_width = data[30:0];
         CSR_HALF_HGT:   view.half_height = data[30:0];
         CSR_COLS:       view.cols = data[9:0];
         CSR_ROWS:       view.rows = data[7:0];
         default: ;
      endcase
      reg_writes++;
   endtask

   task automatic load_view(logic [31:0] cre, logic [31:0] cim, logic [31:0] hw,
         logic [31:0] hh, logic [31:0] cols, logic [31:0] rows);
      go_idle();
      wait_drained();
      write_reg(CSR_CENTER_RE, cre);
      write_reg(CSR_CENTER_IM, cim);
      write_reg(CSR_HALF_WIDTH, hw);
      write_reg(CSR_HALF_HGT, hh);
      write_reg(CSR_COLS, cols);
      write_reg(CSR_ROWS, rows);
      csr_valid <= 1'b0;
   endtask

   // ---------------------------------------------------------------- tests

   // default view after reset: corners, center, cells past the active area
   task automatic test_reset_view();
      send_pixel(9'd0, 7'd0);
      send_pixel(9'd255, 7'd63);
      send_pixel(9'd128, 7'd32);
      send_pixel(9'd100, 7'd40);
      send_pixel(9'd511, 7'd127);
      send_pixel(9'd300, 7'd0);
      send_pixel(9'd0, 7'd100);
   endtask

   // degenerate and oversized grids, saturated plane coordinates
   task automatic test_view_extremes();
      // one column, zero rows: both axes stay on the center
      load_view(32'hfc00_0000, 32'h0000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'd1, 32'd0);
      send_pixel(9'd0, 7'd0);
      send_pixel(9'd511, 7'd127);
      // dimensions above the grid saturate; widest spans
      load_view(32'h0, 32'h0, 32'h7fff_ffff, 32'h7fff_ffff, 32'd1023, 32'd255);
      send_pixel(9'd0, 7'd0);
      send_pixel(9'd511, 7'd127);
      send_pixel(9'd256, 7'd64);
      // centers at the range limits push c into saturation
      load_view(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'd2, 32'd2);
      send_pixel(9'd1, 7'd0);
      send_pixel(9'd0, 7'd1);
      send_pixel(9'd511, 7'd127);
      load_view(32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h0, 32'd512, 32'd128);
      send_pixel(9'd17, 7'd5);
      // zero span on the origin: every cell is inside the set
      load_view(32'h0, 32'h0, 32'h0, 32'h0, 32'd0, 32'd1);
      send_pixel(9'd3, 7'd9);
   endtask

   // random views, mostly near the set boundary so all bands show up
   task automatic random_view();
      logic [31:0] cre, cim, hw, hh, cols, rows;
      cre = $urandom_range(0, 3) == 0 ? $urandom : 32'hfa00_0000 + $urandom_range(0, 32'h0600_0000);
      cim = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
      hw  = $urandom_range(0, 4) == 0 ? $urandom : $urandom_range(1, 32'h1800_0000);
      hh  = $urandom_range(0, 4) == 0 ? $urandom : $urandom_range(1, 32'h1000_0000);
      cols = $urandom_range(0, 5) == 0 ? $urandom : $urandom_range(2, 512);
      rows = $urandom_range(0, 5) == 0 ? $urandom : $urandom_range(2, 128);
      load_view(cre, cim, hw, hh, cols, rows);
   endtask

   task automatic test_random_pixels(int phases, int per_phase);
      for (int ph = 0; ph < phases; ph++) begin
         random_view();
         rsp_stalls_on = (ph % 3) != 0;
         for (int i = 0; i < per_phase; i++) begin
            if (i == per_phase / 2 && ph % 2 == 0) begin
               // hold off until the pipeline empties, then resume
               go_idle();
               wait_drained();
            end
            send_pixel(9'($urandom_range(0, 511)), 7'($urandom_range(0, 127)));
         end
      end
   endtask

   initial begin
      view = '{center_re: -32'sd67108864, center_im: 32'sd0, half_width: 31'd335544320,
               half_height: 31'd174483046, cols: 10'd256, rows: 8'd64};
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_view();
      test_view_extremes();
      test_random_pixels(10, 78);

      go_idle();
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("ran %0d pixels over %0d register writes; bands seen mask %b",
               pixels_sent, reg_writes, bands_seen);
      $display("views covered degenerate, oversized and saturated grids plus random views");
      if (mismatches == 0 && expected_pixels.size() == 0)
         $display("mandelbrot_escape_time_pixel_top: match");
      else begin
         $display("%0d errors, %0d results still owed", mismatches, expected_pixels.size());
         $display("mandelbrot_escape_time_pixel_top: mismatch");
      end
      $finish;
   end

endmodule
